[rtl/sus_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sus_pkg: shared types and constants for the sorted unique id set
// Field widths, request codes and the cell control/status structs.
// ----------------------------------------------------------------------------
package sus_pkg;

  localparam int ID_W        = 32;
  localparam int OP_W        = 3;
  localparam int IDX_W       = 4;
  localparam int CNT_OUT_W   = 5;
  localparam int CAPACITY_DEF = 16;

  // hash fold: h = rotl(h, HASH_ROT) ^ entry
  localparam int HASH_ROT    = 4;

  // request codes; the rest of the code space is a no-op
  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_HASH   = 3'd4;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [ID_W-1:0]  id;
  } cell_ctl_t;

  typedef struct packed {
    logic below;  // valid and entry < id (signed)
    logic match;  // valid and entry == id
  } cell_stat_t;

endpackage : sus_pkg
`default_nettype wire

[rtl/sorted_unique_id_set_core.sv]
`default_nettype none
// Add, remove, clear, read and no-op items wait in the item register, then their results
//   register at the output. Throughput: one such item per cycle when the output is free;
//   a hash holds the block until the chain turns once, one entry into the fold per cycle.
// Reset (rst_n low, synchronous): the set is empty, no item is held, no result is shown.
//   The id cells themselves are not cleared; slots past the count are never used.
// ----------------------------------------------------------------------------
// sorted_unique_id_set_core: sorted set of signed ids in a chain of cells
// Keeps up to CAPACITY ids in ascending signed order without duplicates.
// Each item adds, removes, clears, reads one entry or hashes the set; other codes are no-ops.
// ----------------------------------------------------------------------------
module sorted_unique_id_set_core
  import sus_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic        [OP_W-1:0]      in_operation,
  input  wire logic signed [ID_W-1:0]      in_owner_id,
  input  wire logic        [IDX_W-1:0]     in_entry_index,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_changed,
  output logic                             out_full_reject,
  output logic             [CNT_OUT_W-1:0] out_entry_count,
  output logic signed      [ID_W-1:0]      out_read_value
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W = $clog2(CAPACITY);
  // only the first slots are reachable by the 4-bit read index
  localparam int RD_N   = (CAPACITY < (1 << IDX_W)) ? CAPACITY : (1 << IDX_W);

  // --------------------------------------------------------------------------
  // Item holding register: parts the input handshake from the chain so a new
  // item can be taken while a finished result still waits at the output.
  // --------------------------------------------------------------------------
  logic              pend_valid_r;
  logic [OP_W-1:0]   pend_op_r;
  logic [ID_W-1:0]   pend_id_r;
  logic [IDX_W-1:0]  pend_idx_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  // hash walk: the chain rotates one full turn, slot 0 feeds the fold
  logic              hash_busy_r;
  logic              hash_done_r;
  logic [STEP_W-1:0] step_r;
  logic [ID_W-1:0]   hash_r;

  logic              out_valid_r;
  logic              out_changed_r;
  logic              out_reject_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic [ID_W-1:0]   out_value_r;

  logic              out_free;
  logic              is_hash;
  logic              exec_fire;
  logic              hash_start;
  logic              in_fire;

  logic              found;
  logic              full;
  logic              res_changed;
  logic              res_reject;
  logic [ID_W-1:0]   res_value;
  logic [ID_W-1:0]   rd_word;

  cell_ctl_t         ctl;
  cell_stat_t        stat   [CAPACITY];
  logic [ID_W-1:0]   entries[CAPACITY];
  logic [CAPACITY-1:0] match_vec;

  assign out_free   = !out_valid_r || !out_stall;
  assign is_hash    = pend_op_r == OP_HASH;
  // a hash item completes only once its walk is done
  assign exec_fire  = pend_valid_r && out_free && (!is_hash || hash_done_r);
  assign hash_start = pend_valid_r && is_hash && !hash_busy_r && !hash_done_r;
  assign in_stall   = pend_valid_r && !exec_fire;
  assign in_fire    = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Cell chain. Insert shifts right from the insert point, remove shifts
  // left onto the matching slot, rotate turns the whole ring by one.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic            take_w;
    logic [ID_W-1:0] left_w;
    logic [ID_W-1:0] right_w;

    if (g == 0) begin : g_head
      assign take_w = 1'b1;
      assign left_w = pend_id_r;
    end else begin : g_body
      assign take_w = stat[g-1].below;
      assign left_w = entries[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = entries[0];   // closes the ring for rotate
    end else begin : g_mid
      assign right_w = entries[g+1];
    end

    sus_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count_r),
      .take_in     (take_w),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry       (entries[g]),
      .stat        (stat[g])
    );

    assign match_vec[g] = stat[g].match;
  end

  assign found = |match_vec;
  assign full  = count_r == CNT_W'(CAPACITY);

  // --------------------------------------------------------------------------
  // Chain command and the result of the held item
  // --------------------------------------------------------------------------
  always_comb begin
    ctl.id  = pend_id_r;
    ctl.cmd = CMD_HOLD;
    if (hash_busy_r) begin
      ctl.cmd = CMD_ROTATE;
    end else if (exec_fire && pend_op_r == OP_ADD && !found && !full) begin
      ctl.cmd = CMD_INSERT;
    end else if (exec_fire && pend_op_r == OP_REMOVE && found) begin
      ctl.cmd = CMD_REMOVE;
    end
  end

  // read mux over the slots the index can reach
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (pend_idx_r == IDX_W'(k)) begin
        rd_word = entries[k];
      end
    end
  end

  always_comb begin
    res_changed = 1'b0;
    res_reject  = 1'b0;
    res_value   = '0;
    count_nxt   = count_r;
    case (pend_op_r)
      OP_ADD: begin
        if (found) begin
          res_changed = 1'b0;     // already held
        end else if (full) begin
          res_reject  = 1'b1;
        end else begin
          res_changed = 1'b1;
          count_nxt   = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          res_changed = 1'b1;
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        res_changed = count_r != '0;
        count_nxt   = '0;
      end
      OP_READ: begin
        if ((int'(pend_idx_r) < int'(count_r)) && (int'(pend_idx_r) < CAPACITY)) begin
          res_value = rd_word;
        end
      end
      OP_HASH: begin
        res_value = hash_r;
      end
      default: begin
        res_value = '0;           // undefined codes change nothing
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      count_r      <= '0;
      hash_busy_r  <= 1'b0;
      hash_done_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        pend_valid_r <= 1'b1;
      end else if (exec_fire) begin
        pend_valid_r <= 1'b0;
      end

      if (exec_fire) begin
        count_r <= count_nxt;
      end

      if (hash_start) begin
        hash_busy_r <= 1'b1;
      end else if (hash_busy_r && step_r == STEP_W'(CAPACITY - 1)) begin
        hash_busy_r <= 1'b0;
        hash_done_r <= 1'b1;
      end else if (exec_fire) begin
        hash_done_r <= 1'b0;
      end

      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_op_r  <= in_operation;
      pend_id_r  <= in_owner_id;
      pend_idx_r <= in_entry_index;
    end

    if (hash_start) begin
      step_r <= '0;
      hash_r <= '0;
    end else if (hash_busy_r) begin
      step_r <= step_r + STEP_W'(1);
      // slots past the count ride the ring but stay out of the fold
      if (CNT_W'(step_r) < count_r) begin
        hash_r <= {hash_r[ID_W-HASH_ROT-1:0], hash_r[ID_W-1:ID_W-HASH_ROT]} ^ entries[0];
      end
    end

    if (exec_fire) begin
      out_changed_r <= res_changed;
      out_reject_r  <= res_reject;
      out_count_r   <= CNT_OUT_W'(count_nxt);
      out_value_r   <= res_value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_changed     = out_changed_r;
  assign out_full_reject = out_reject_r;
  assign out_entry_count = out_count_r;
  assign out_read_value  = $signed(out_value_r);

endmodule : sorted_unique_id_set_core
`default_nettype wire

[rtl/sus_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sus_cell: one slot of the sorted id chain
// Holds one id, compares it with the broadcast id and moves data between
// neighbors on insert (shift right), remove and rotate (shift left).
// ----------------------------------------------------------------------------
module sus_cell
  import sus_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             take_in,
  input  wire logic [ID_W-1:0]  left_entry,
  input  wire logic [ID_W-1:0]  right_entry,
  output logic      [ID_W-1:0]  entry,
  output cell_stat_t            stat
);

  logic [ID_W-1:0] entry_r;
  logic [ID_W-1:0] entry_nxt;
  logic            valid;

  assign valid      = CNT_W'(IDX) < count;
  assign stat.below = valid && ($signed(entry_r) < $signed(ctl.id));
  assign stat.match = valid && (entry_r == ctl.id);
  assign entry      = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (!stat.below) begin
          entry_nxt = take_in ? ctl.id : left_entry;
        end
      end
      CMD_REMOVE: begin
        if (!stat.below) begin
          entry_nxt = right_entry;
        end
      end
      CMD_ROTATE: begin
        entry_nxt = right_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule : sus_cell
`default_nettype wire

[sim/sorted_unique_id_set_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_unique_id_set_core_test: self-checking bench for the sorted id set
// Opens with a short table of directed requests, then sends random request
// sequences built around the live set. Every result is compared against an
// in-bench shadow of the set, or the inline result of a typed opening row,
// with random idling on both channels.
module sorted_unique_id_set_core_test;
  import sus_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1250;
  // long enough for a hash walk to finish, with a margin on top
  localparam int TAIL_CYCLES  = 2 * CAPACITY_DEF + 8;
  // worst run: ~1300 items, each with a long send gap, a hash and a long stall
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam logic signed [ID_W-1:0] ID_MIN = 32'sh8000_0000;
  localparam logic signed [ID_W-1:0] ID_MAX = 32'sh7fff_ffff;
  // codes past OP_HASH do nothing
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic                    changed;
    logic                    full_reject;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic signed [ID_W-1:0]  read_value;
  } set_result_t;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [ID_W-1:0]  id;
    logic [IDX_W-1:0]        idx;
    bit                      typed;  // use the result column, not the shadow set
    set_result_t             want;
  } opening_row_t;

  localparam int NUM_OPENING = 23;

  // Opening requests. Rows with typed = 1 carry their result inline.
  opening_row_t opening_rows [NUM_OPENING] = '{
    // empty set: read, hash, clear, remove and an unused code do nothing
    '{OP_READ,      32'sd0,  4'd0,  1'b1, '{1'b0, 1'b0, 5'd0, 32'sd0}},
    '{OP_HASH,      32'sd0,  4'd0,  1'b1, '{1'b0, 1'b0, 5'd0, 32'sd0}},
    '{OP_CLEAR,     32'sd0,  4'd0,  1'b1, '{1'b0, 1'b0, 5'd0, 32'sd0}},
    '{OP_REMOVE,    ID_MIN,  4'd0,  1'b1, '{1'b0, 1'b0, 5'd0, 32'sd0}},
    '{OP_UNUSED_HI, -32'sd1, 4'd15, 1'b1, '{1'b0, 1'b0, 5'd0, 32'sd0}},
    // extremes, inserted out of order, then a duplicate
    '{OP_ADD,       ID_MAX,  4'd0,  1'b1, '{1'b1, 1'b0, 5'd1, 32'sd0}},
    '{OP_ADD,       ID_MIN,  4'd0,  1'b1, '{1'b1, 1'b0, 5'd2, 32'sd0}},
    '{OP_ADD,       ID_MIN,  4'd0,  1'b1, '{1'b0, 1'b0, 5'd2, 32'sd0}},
    '{OP_READ,      32'sd0,  4'd0,  1'b1, '{1'b0, 1'b0, 5'd2, ID_MIN}},
    '{OP_READ,      32'sd0,  4'd1,  1'b1, '{1'b0, 1'b0, 5'd2, ID_MAX}},
    // read past the count
    '{OP_READ,      32'sd0,  4'd15, 1'b1, '{1'b0, 1'b0, 5'd2, 32'sd0}},
    '{OP_UNUSED_LO, 32'sd0,  4'd0,  1'b1, '{1'b0, 1'b0, 5'd2, 32'sd0}},
    // ids around zero land between the extremes
    '{OP_ADD,       -32'sd1, 4'd0,  1'b0, '0},
    '{OP_ADD,       32'sd0,  4'd0,  1'b0, '0},
    '{OP_ADD,       32'sd1,  4'd0,  1'b0, '0},
    '{OP_HASH,      32'sd0,  4'd0,  1'b0, '0},
    '{OP_READ,      32'sd0,  4'd2,  1'b0, '0},
    '{OP_REMOVE,    32'sd0,  4'd0,  1'b0, '0},
    // same id again: now absent
    '{OP_REMOVE,    32'sd0,  4'd0,  1'b0, '0},
    '{OP_REMOVE,    ID_MAX,  4'd0,  1'b0, '0},
    '{OP_HASH,      32'sd0,  4'd0,  1'b0, '0},
    '{OP_CLEAR,     32'sd0,  4'd0,  1'b1, '{1'b1, 1'b0, 5'd0, 32'sd0}},
    '{OP_HASH,      32'sd0,  4'd0,  1'b1, '{1'b0, 1'b0, 5'd0, 32'sd0}}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_operation = '0;
  logic signed [ID_W-1:0]  in_owner_id = '0;
  logic [IDX_W-1:0]        in_entry_index = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_changed;
  logic                    out_full_reject;
  logic [CNT_OUT_W-1:0]    out_entry_count;
  logic signed [ID_W-1:0]  out_read_value;

  // shadow of the set: ascending signed order, no duplicates
  logic signed [ID_W-1:0]  shadow_ids [CAPACITY_DEF];
  int                      shadow_count = 0;

  set_result_t             awaited_results [$];
  set_result_t             oldest_awaited;
  int                      fail_count = 0;
  int                      result_count = 0;
  int                      request_count = 0;  // no-op codes are not counted
  int                      cycle_count = 0;

  bit                      tx_idle_on = 1'b1;
  bit                      rx_quiet = 1'b0;
  int                      rx_hold = 0;
  int                      rx_phase_left = 0;

  sorted_unique_id_set_core #(
    .CAPACITY(CAPACITY_DEF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_owner_id(in_owner_id),
    .in_entry_index(in_entry_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_changed(out_changed),
    .out_full_reject(out_full_reject),
    .out_entry_count(out_entry_count),
    .out_read_value(out_read_value)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog: a missing result or a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report(input string what);
    if (fail_count < 40)
      $display("mismatch: %s", what);
    fail_count++;
  endtask

  // Apply one request to the shadow set and return the result it should give.
  function automatic set_result_t apply_to_shadow_set(input logic [OP_W-1:0] op,
                                                      input logic signed [ID_W-1:0] id,
                                                      input logic [IDX_W-1:0] idx);
    set_result_t             res;
    int                      slot;
    int                      j;
    logic signed [ID_W-1:0]  fold;
    res = '0;
    slot = 0;
    fold = '0;
    // first slot whose id is not below the request id
    while (slot < shadow_count && shadow_ids[slot] < id)
      slot++;
    case (op)
      OP_ADD: begin
        if (slot < shadow_count && shadow_ids[slot] == id) begin
          // already held: nothing to do
        end else if (shadow_count >= CAPACITY_DEF) begin
          res.full_reject = 1'b1;
        end else begin
          for (j = shadow_count; j > slot; j--)
            shadow_ids[j] = shadow_ids[j-1];
          shadow_ids[slot] = id;
          shadow_count++;
          res.changed = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (slot < shadow_count && shadow_ids[slot] == id) begin
          for (j = slot; j + 1 < shadow_count; j++)
            shadow_ids[j] = shadow_ids[j+1];
          shadow_count--;
          res.changed = 1'b1;
        end
      end
      OP_CLEAR: begin
        res.changed = (shadow_count != 0);
        shadow_count = 0;
      end
      OP_READ: begin
        if (idx < shadow_count)
          res.read_value = shadow_ids[idx];
      end
      OP_HASH: begin
        // fold first to last: rotate left, then xor in the next id
        for (j = 0; j < shadow_count; j++)
          fold = {fold[ID_W-HASH_ROT-1:0], fold[ID_W-1:ID_W-HASH_ROT]} ^ shadow_ids[j];
        res.read_value = fold;
      end
      default: ;
    endcase
    res.entry_count = shadow_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  // Sender gap: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!tx_idle_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Any read index, held or not.
  function automatic logic [IDX_W-1:0] pick_idx();
    return IDX_W'($urandom_range(0, 15));
  endfunction

  // Extremes and a small range around zero give duplicates and edge orders.
  function automatic logic signed [ID_W-1:0] pick_id();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return ID_MIN;
          1: return ID_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: begin
        v = $urandom_range(0, 16);
        return v - 8;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [ID_W-1:0] pick_held_id();
    if (shadow_count == 0)
      return pick_id();
    return shadow_ids[$urandom_range(0, shadow_count - 1)];
  endfunction

  // Drive one item and hold it until accepted. Valid stays high into the
  // next item when there is no gap, so it is never dropped and raised in
  // the same step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [ID_W-1:0] id,
                           input logic [IDX_W-1:0] idx, input bit typed,
                           input set_result_t want);
    set_result_t predicted;
    int          gap;
    in_valid <= 1'b1;
    in_operation <= op;
    in_owner_id <= id;
    in_entry_index <= idx;
    do @(posedge clk); while (in_stall);
    // accepted at this edge; the shadow set moves on with it
    predicted = apply_to_shadow_set(op, id, idx);
    awaited_results.push_back(typed ? want : predicted);
    if (op <= OP_HASH)
      request_count++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [ID_W-1:0] id,
                         input logic [IDX_W-1:0] idx);
    send_item(op, id, idx, 1'b0, '0);
  endtask

  // Hold off the sender until every awaited result is back.
  task automatic settle_sender();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // One request against the live set, weighted toward ones that change it.
  task automatic send_mixed();
    int              r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 25)
      send_op(OP_ADD, pick_id(), pick_idx());
    else if (r < 35)
      send_op(OP_ADD, pick_held_id(), pick_idx());
    else if (r < 55)
      send_op(OP_REMOVE, pick_held_id(), pick_idx());
    else if (r < 63)
      send_op(OP_REMOVE, pick_id(), pick_idx());
    else if (r < 78)
      send_op(OP_READ, pick_id(),
              (shadow_count == 0) ? pick_idx() :
                                    IDX_W'($urandom_range(0, shadow_count - 1)));
    else if (r < 85)
      send_op(OP_READ, pick_id(), pick_idx());
    else if (r < 94)
      send_op(OP_HASH, pick_id(), pick_idx());
    else if (r < 97)
      send_op(OP_CLEAR, pick_id(), pick_idx());
    else begin
      op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      send_op(op, $urandom, pick_idx());
    end
  endtask

  // One random sequence. The kind picks its shape; contents are random.
  task automatic run_sequence(input int kind);
    int              n;
    int              k;
    logic [OP_W-1:0] op;
    tx_idle_on = ($urandom_range(0, 3) != 0);
    if (kind < 30) begin
      // fill past capacity: the tail of the run hits the full store
      n = $urandom_range(CAPACITY_DEF + 2, CAPACITY_DEF + 6);
      repeat (n) send_op(OP_ADD, pick_id(), pick_idx());
      // add of a held id while full is not a reject
      send_op(OP_ADD, pick_held_id(), pick_idx());
      send_op(OP_HASH, pick_id(), pick_idx());
    end else if (kind < 60) begin
      n = $urandom_range(15, 30);
      repeat (n) send_mixed();
    end else if (kind < 72) begin
      // drain by removes, with some misses mixed in
      while (shadow_count != 0) begin
        if ($urandom_range(0, 4) == 0)
          send_op(OP_REMOVE, pick_id(), pick_idx());
        else
          send_op(OP_REMOVE, pick_held_id(), pick_idx());
      end
      send_op(OP_CLEAR, pick_id(), pick_idx());
      send_op(OP_HASH, pick_id(), pick_idx());
    end else if (kind < 82) begin
      // read every slot, held or not, then hash
      for (k = 0; k < 16; k++)
        send_op(OP_READ, pick_id(), k[IDX_W-1:0]);
      send_op(OP_HASH, pick_id(), pick_idx());
    end else if (kind < 94) begin
      // unshaped noise over the whole code space
      n = $urandom_range(5, 12);
      repeat (n) begin
        op = OP_W'($urandom_range(0, 7));
        send_op(op, $urandom, pick_idx());
      end
    end else begin
      send_op(OP_CLEAR, pick_id(), pick_idx());
      settle_sender();
    end
  endtask

  // Receiver: stalls of random length, with quiet phases of no stall at all.
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_quiet = ($urandom_range(0, 3) == 0);
      rx_phase_left = $urandom_range(50, 400);
    end else begin
      rx_phase_left--;
    end
    if (rx_hold != 0)
      rx_hold--;
    else if (!rx_quiet && $urandom_range(0, 99) < 30)
      rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    out_stall <= (rx_hold != 0);
  end

  // Result checker: each accepted result against the oldest awaited one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing awaited", result_count));
      end else begin
        oldest_awaited = awaited_results.pop_front();
        if (out_changed !== oldest_awaited.changed)
          report($sformatf("result %0d changed: got %b want %b",
                           result_count, out_changed, oldest_awaited.changed));
        if (out_full_reject !== oldest_awaited.full_reject)
          report($sformatf("result %0d full_reject: got %b want %b",
                           result_count, out_full_reject, oldest_awaited.full_reject));
        if (out_entry_count !== oldest_awaited.entry_count)
          report($sformatf("result %0d entry_count: got %0d want %0d",
                           result_count, out_entry_count, oldest_awaited.entry_count));
        if (out_read_value !== oldest_awaited.read_value)
          report($sformatf("result %0d read_value: got %0d want %0d",
                           result_count, out_read_value, oldest_awaited.read_value));
      end
      result_count++;
    end
  end

  initial begin
    int row;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < NUM_OPENING; row++)
      send_item(opening_rows[row].op, opening_rows[row].id, opening_rows[row].idx,
                opening_rows[row].typed, opening_rows[row].want);
    // sender waits for the block to drain at least once
    settle_sender();

    // start random traffic with a fill, so the full store is reached early
    run_sequence(0);
    while (request_count < NUM_OPENING + RANDOM_ITEMS)
      run_sequence($urandom_range(0, 99));

    settle_sender();
    // a late hash or stray result would show up within this window
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/sus_pkg.sv
rtl/sus_cell.sv
rtl/sorted_unique_id_set_core.sv
sim/sorted_unique_id_set_core_test.sv
